FILE: design/hmsbf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmsbf_pkg: shared types and constants
// Beat formats, pixel and sum types, register offsets, sequencer states and
// the reciprocals used by the constant divider.
// ----------------------------------------------------------------------------
package hmsbf_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	typedef logic signed [25:0] pix_t;
	typedef pix_t [2:0] pix_col_t;
	typedef logic signed [28:0] sum_t;

	typedef struct packed {
		logic [7:0] raw_height;
		logic       pad;
	} in_beat_t;

	typedef struct packed {
		logic signed [25:0] mean_height;
		logic [15:0]        out_row;
		logic [9:0]         out_col;
		logic               frame_end;
	} out_beat_t;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_SCALE  = 2'd2;
	localparam logic [1:0] REG_OFFSET = 2'd3;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_CSUM = 6'b000100,
		ST_SEL  = 6'b001000,
		ST_MUL  = 6'b010000,
		ST_FIX  = 6'b100000
	} state_t;

	typedef enum logic [1:0] {
		DIV1 = 2'd0,
		DIV3 = 2'd1,
		DIV9 = 2'd2
	} div_t;

	localparam int          RECIP_SHIFT = 30;
	localparam logic [29:0] RECIP3      = 30'd357913941;
	localparam logic [29:0] RECIP9      = 30'd119304647;

endpackage
`default_nettype wire

FILE: design/hmsbf_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmsbf_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hmsbf_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: design/hmsbf_col_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hmsbf_col_cell: one column of the 3x3 window
// Holds three scaled pixels, passes them to the left neighbor on a shift and
// forms the masked sum of its rows.
// ----------------------------------------------------------------------------
module hmsbf_col_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift_en,
	input  wire logic              sum_en,
	input  wire hmsbf_pkg::pix_col_t pix_in,
	input  wire logic [2:0]        row_mask,
	output hmsbf_pkg::pix_col_t    pix_out,
	output hmsbf_pkg::sum_t        col_sum
);

	hmsbf_pkg::pix_col_t pix_q;
	hmsbf_pkg::sum_t     sum_q;
	hmsbf_pkg::sum_t     sum_d;

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < 3; i++) begin
			if (row_mask[i]) begin
				sum_d = sum_d + hmsbf_pkg::sum_t'(pix_q[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
		end else if (shift_en) begin
			pix_q <= pix_in;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_en) begin
			sum_q <= sum_d;
		end
	end

	assign pix_out = pix_q;
	assign col_sum = sum_q;

endmodule
`default_nettype wire

FILE: design/heightmap_scale_box_filter3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heightmap_scale_box_filter3x3: scaled height map with 3x3 mean filter
// Scales raw bytes to Q.8, keeps two line buffers and a 3x3 window of
// column cells, and emits the edge-normalized rounded mean of each pixel.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | beat
//  pix     | in        | pix_valid/pix_stall | in_beat_t (raw_height, pad)
//  res     | out       | res_valid/res_stall | out_beat_t (mean, row, col, end)
//  apb     | in/out    | psel/penable/pready | 32-bit registers at 4*i
//
// An input beat passes the load and column-sum states, and each of its results
// the select, multiply and fix states. The sequencer shares one multiply-based
// divider between the two results and reads the line buffer RAM once per beat.
// Reset clears the counters, window and sequencer; line buffers are not
// cleared. A stalled result holds the divider in its final step.
module heightmap_scale_box_filter3x3 #(
	parameter int MAX_WIDTH = hmsbf_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                pix_valid,
	output logic                     pix_stall,
	input  wire hmsbf_pkg::in_beat_t pix_data,
	output logic                     res_valid,
	input  wire logic                res_stall,
	output hmsbf_pkg::out_beat_t     res_data,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = CW + 1;

	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [15:0] scale_q;
	logic [23:0] offset_q;

	logic [EW-1:0] eff_w;
	logic [15:0]   eff_h;

	hmsbf_pkg::state_t state_q;
	logic [15:0]       row_q, r_q;
	logic [CW-1:0]     col_q, c_q;
	hmsbf_pkg::pix_t   v_q;
	logic              pend_a_q, pend_b_q;

	logic              mag_neg_q;
	logic [27:0]       mag_q;
	hmsbf_pkg::div_t   div_q;
	logic [57:0]       prod_q;
	logic [15:0]       orow_q;
	logic [CW-1:0]     ocol_q;
	logic              oend_q;

	logic                 res_valid_q;
	hmsbf_pkg::out_beat_t res_q;

	logic accept, cfg_wr, out_free, last_col;
	logic [51:0] ram_rdata;
	hmsbf_pkg::pix_col_t col_data [4];
	hmsbf_pkg::sum_t     col_sum [3];
	logic [2:0]          row_mask;

	logic [23:0]     prod_raw;
	hmsbf_pkg::pix_t v_d;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite && pready;
	assign pix_stall = (state_q != hmsbf_pkg::ST_IDLE);
	assign accept    = pix_valid && !pix_stall;
	assign out_free  = !res_valid_q || !res_stall;

	always_comb begin
		if (width_q == 11'd0) begin
			eff_w = EW'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = EW'(width_q);
		end
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	always_comb begin
		case (paddr[3:2])
			hmsbf_pkg::REG_WIDTH:  prdata = 32'(width_q);
			hmsbf_pkg::REG_HEIGHT: prdata = 32'(height_q);
			hmsbf_pkg::REG_SCALE:  prdata = 32'(scale_q);
			hmsbf_pkg::REG_OFFSET: prdata = 32'(offset_q);
			default:               prdata = '0;
		endcase
	end

	assign prod_raw = 24'(pix_data.raw_height) * 24'(scale_q);
	assign v_d = (row_q < eff_h)
		? ($signed({2'b00, prod_raw}) + $signed({{2{offset_q[23]}}, offset_q}))
		: '0;

	hmsbf_ram #(
		.WIDTH(52),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (state_q == hmsbf_pkg::ST_LOAD),
		.waddr(c_q),
		.wdata({ram_rdata[25:0], v_q}),
		.re   (accept),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// Newest column enters at the right end: older row, row above, current.
	assign col_data[3] = {v_q, hmsbf_pkg::pix_t'(ram_rdata[25:0]),
		hmsbf_pkg::pix_t'(ram_rdata[51:26])};
	assign row_mask = {r_q < eff_h, r_q >= 16'd1, r_q >= 16'd2};

	for (genvar j = 0; j < 3; j++) begin : g_cell
		hmsbf_col_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift_en(state_q == hmsbf_pkg::ST_LOAD),
			.sum_en  (state_q == hmsbf_pkg::ST_CSUM),
			.pix_in  (col_data[j+1]),
			.row_mask(row_mask),
			.pix_out (col_data[j]),
			.col_sum (col_sum[j])
		);
	end

	assign last_col = ({1'b0, c_q} == eff_w - EW'(1));

	// Result selection and magnitude with the rounding half added.
	logic            sel_a;
	hmsbf_pkg::sum_t sel_sum;
	logic [1:0]      n_rows, n_cols;
	logic [3:0]      cnt;
	logic [28:0]     abs_sum;
	logic [27:0]     mag_d;
	logic [1:0]      sh_d;
	hmsbf_pkg::div_t div_d;

	always_comb begin
		sel_a  = pend_a_q;
		n_rows = 2'(row_mask[0]) + 2'(row_mask[1]) + 2'(row_mask[2]);
		n_cols = 2'd1 + 2'(c_q >= CW'(1));
		if (sel_a) begin
			n_cols  = n_cols + 2'(c_q >= CW'(2));
			sel_sum = col_sum[2] + col_sum[1] + ((c_q >= CW'(2)) ? col_sum[0] : '0);
		end else begin
			sel_sum = col_sum[2] + ((c_q >= CW'(1)) ? col_sum[1] : '0);
		end
		cnt = 4'(n_rows) * 4'(n_cols);
		case (cnt)
			4'd2:    begin sh_d = 2'd1; div_d = hmsbf_pkg::DIV1; end
			4'd3:    begin sh_d = 2'd0; div_d = hmsbf_pkg::DIV3; end
			4'd4:    begin sh_d = 2'd2; div_d = hmsbf_pkg::DIV1; end
			4'd6:    begin sh_d = 2'd1; div_d = hmsbf_pkg::DIV3; end
			4'd9:    begin sh_d = 2'd0; div_d = hmsbf_pkg::DIV9; end
			default: begin sh_d = 2'd0; div_d = hmsbf_pkg::DIV1; end
		endcase
		abs_sum = sel_sum[28] ? 29'(-sel_sum) : 29'(sel_sum);
		mag_d   = (28'(abs_sum) + 28'(cnt >> 1)) >> sh_d;
	end

	// Quotient correction: the reciprocal estimate is at most one low.
	logic [27:0]     q0, q_fix;
	logic [31:0]     q0b, rem;
	hmsbf_pkg::pix_t mean_d;

	always_comb begin
		q0 = prod_q[hmsbf_pkg::RECIP_SHIFT +: 28];
		case (div_q)
			hmsbf_pkg::DIV3: q0b = 32'(q0) + (32'(q0) << 1);
			hmsbf_pkg::DIV9: q0b = 32'(q0) + (32'(q0) << 3);
			default:         q0b = 32'(q0);
		endcase
		rem = 32'(mag_q) - q0b;
		case (div_q)
			hmsbf_pkg::DIV3: q_fix = (rem >= 32'd3) ? q0 + 28'd1 : q0;
			hmsbf_pkg::DIV9: q_fix = (rem >= 32'd9) ? q0 + 28'd1 : q0;
			default:         q_fix = mag_q;
		endcase
		mean_d = mag_neg_q ? -hmsbf_pkg::pix_t'(q_fix) : hmsbf_pkg::pix_t'(q_fix);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd256;
			height_q <= 16'd256;
			scale_q  <= 16'd256;
			offset_q <= '0;
			state_q  <= hmsbf_pkg::ST_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			pend_a_q <= 1'b0;
			pend_b_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == hmsbf_pkg::ST_FIX && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				case (paddr[3:2])
					hmsbf_pkg::REG_WIDTH: begin
						width_q <= pwdata[10:0];
						row_q   <= '0;
						col_q   <= '0;
					end
					hmsbf_pkg::REG_HEIGHT: begin
						height_q <= pwdata[15:0];
						row_q    <= '0;
						col_q    <= '0;
					end
					hmsbf_pkg::REG_SCALE:  scale_q  <= pwdata[15:0];
					hmsbf_pkg::REG_OFFSET: offset_q <= pwdata[23:0];
					default: ;
				endcase
			end
			case (state_q)
				hmsbf_pkg::ST_IDLE: begin
					if (accept) begin
						state_q <= hmsbf_pkg::ST_LOAD;
						if ({1'b0, col_q} == eff_w - EW'(1)) begin
							col_q <= '0;
							row_q <= (row_q == eff_h) ? '0 : row_q + 16'd1;
						end else begin
							col_q <= col_q + CW'(1);
						end
					end
				end
				hmsbf_pkg::ST_LOAD: state_q <= hmsbf_pkg::ST_CSUM;
				hmsbf_pkg::ST_CSUM: begin
					pend_a_q <= (r_q >= 16'd1) && (c_q >= CW'(1));
					pend_b_q <= (r_q >= 16'd1) && last_col;
					state_q  <= ((r_q >= 16'd1) && ((c_q >= CW'(1)) || last_col))
						? hmsbf_pkg::ST_SEL : hmsbf_pkg::ST_IDLE;
				end
				hmsbf_pkg::ST_SEL: begin
					if (sel_a) begin
						pend_a_q <= 1'b0;
					end else begin
						pend_b_q <= 1'b0;
					end
					state_q <= hmsbf_pkg::ST_MUL;
				end
				hmsbf_pkg::ST_MUL: state_q <= hmsbf_pkg::ST_FIX;
				hmsbf_pkg::ST_FIX: begin
					if (out_free) begin
						state_q <= (pend_a_q || pend_b_q) ? hmsbf_pkg::ST_SEL
							: hmsbf_pkg::ST_IDLE;
					end
				end
				default: state_q <= hmsbf_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q <= v_d;
			r_q <= row_q;
			c_q <= col_q;
		end
		if (state_q == hmsbf_pkg::ST_SEL) begin
			mag_neg_q <= sel_sum[28];
			mag_q     <= mag_d;
			div_q     <= div_d;
			orow_q    <= r_q - 16'd1;
			ocol_q    <= sel_a ? c_q - CW'(1) : c_q;
			oend_q    <= !sel_a && (r_q == eff_h);
		end
		if (state_q == hmsbf_pkg::ST_MUL) begin
			prod_q <= 58'(mag_q) *
				58'((div_q == hmsbf_pkg::DIV9) ? hmsbf_pkg::RECIP9 : hmsbf_pkg::RECIP3);
		end
		if (state_q == hmsbf_pkg::ST_FIX && out_free) begin
			res_q.mean_height <= mean_d;
			res_q.out_row     <= orow_q;
			res_q.out_col     <= 10'(ocol_q);
			res_q.frame_end   <= oend_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");
	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == hmsbf_pkg::ST_LOAD)
		else $error("accepted beat did not start a line buffer load");
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hmsbf_pkg::ST_IDLE) |-> !(pend_a_q || pend_b_q))
		else $error("idle with a result still pending");
	a_fix_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hmsbf_pkg::ST_FIX && out_free) |=> res_valid_q)
		else $error("finished result not presented");
`endif

endmodule
`default_nettype wire

FILE: bench/heightmap_scale_box_filter3x3_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heightmap_scale_box_filter3x3_test: self-checking bench for the 3x3 filter
// Streams raster frames with their flush rows through the block under many
// register settings and random handshake gaps, predicts every filtered pixel
// and compares each result beat with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module heightmap_scale_box_filter3x3_test;

	localparam int MAXW = 1024;
	localparam int CYCLE_LIMIT = 1500000;

	// Tracks the filter state and queues the pixel means each beat produces.
	class box_mean_tracker;
		int unsigned cfg_width = 256;
		int unsigned cfg_height = 256;
		int unsigned cfg_scale = 256;
		int unsigned cfg_offset = 0;
		longint line_prev[MAXW];
		longint line_older[MAXW];
		longint win[3][3];
		int unsigned row_idx = 0;
		int unsigned col_idx = 0;
		hmsbf_pkg::out_beat_t pending_means[$];
		int errors = 0;

		function void write_reg(logic [1:0] idx, int unsigned val);
			case (idx)
				hmsbf_pkg::REG_WIDTH: begin
					cfg_width = val & 32'h7FF;
					row_idx = 0;
					col_idx = 0;
				end
				hmsbf_pkg::REG_HEIGHT: begin
					cfg_height = val & 32'hFFFF;
					row_idx = 0;
					col_idx = 0;
				end
				hmsbf_pkg::REG_SCALE: cfg_scale = val & 32'hFFFF;
				hmsbf_pkg::REG_OFFSET: cfg_offset = val & 32'hFFFFFF;
				default: ;
			endcase
		endfunction

		function longint mean_at(int k, int unsigned r, int unsigned c, int unsigned w,
				int unsigned h);
			longint sum, cnt, half, ar, ac;
			sum = 0;
			cnt = 0;
			for (int i = 0; i < 3; i++) begin
				ar = longint'(r) - 2 + i;
				if (ar < 0 || ar >= h) continue;
				for (int j = k - 1; j <= k + 1 && j < 3; j++) begin
					ac = longint'(c) - 2 + j;
					if (ac < 0 || ac >= w) continue;
					sum += win[i][j];
					cnt++;
				end
			end
			if (cnt == 0) return 0;
			half = cnt / 2;
			if (sum >= 0) return (sum + half) / cnt;
			return -((-sum + half) / cnt);
		endfunction

		function void push_mean(longint m, int unsigned r, int unsigned c, bit last);
			hmsbf_pkg::out_beat_t b;
			b.mean_height = m[25:0];
			b.out_row = r[15:0];
			b.out_col = c[9:0];
			b.frame_end = last;
			pending_means.push_back(b);
		endfunction

		function void take_pixel(hmsbf_pkg::in_beat_t px);
			int unsigned w, h, r, c;
			longint v, off, above, older;
			w = (cfg_width == 0) ? 1 : (cfg_width > MAXW ? MAXW : cfg_width);
			h = (cfg_height == 0) ? 1 : cfg_height;
			r = row_idx;
			c = col_idx;
			off = longint'(cfg_offset);
			if (off >= 64'h800000) off -= 64'h1000000;
			v = (r < h) ? longint'(px.raw_height) * longint'(cfg_scale) + off : 0;
			above = line_prev[c];
			older = line_older[c];
			for (int i = 0; i < 3; i++) begin
				win[i][0] = win[i][1];
				win[i][1] = win[i][2];
			end
			win[0][2] = older;
			win[1][2] = above;
			win[2][2] = v;
			line_older[c] = above;
			line_prev[c] = v;
			if (r >= 1) begin
				if (c >= 1) push_mean(mean_at(1, r, c, w, h), r - 1, c - 1, 1'b0);
				if (c == w - 1) push_mean(mean_at(2, r, c, w, h), r - 1, c, r == h);
			end
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r > h) r = 0;
			end
			row_idx = r;
			col_idx = c;
		endfunction

		function void match_result(hmsbf_pkg::out_beat_t got);
			hmsbf_pkg::out_beat_t want;
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, got);
				errors++;
				return;
			end
			want = pending_means.pop_front();
			if (got.mean_height !== want.mean_height) begin
				$display("%0t: mean_height expected %0d got %0d", $time,
					want.mean_height, got.mean_height);
				errors++;
			end
			if (got.out_row !== want.out_row) begin
				$display("%0t: out_row expected %0d got %0d", $time, want.out_row,
					got.out_row);
				errors++;
			end
			if (got.out_col !== want.out_col) begin
				$display("%0t: out_col expected %0d got %0d", $time, want.out_col,
					got.out_col);
				errors++;
			end
			if (got.frame_end !== want.frame_end) begin
				$display("%0t: frame_end expected %0d got %0d", $time, want.frame_end,
					got.frame_end);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_stall;
	hmsbf_pkg::in_beat_t pix_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	hmsbf_pkg::out_beat_t res_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	box_mean_tracker tracker = new();
	int send_gap_pct = 29;
	int recv_stall_pct = 47;
	int pixels_sent = 0;
	int unsigned cycles = 0;

	heightmap_scale_box_filter3x3 uut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix_data(pix_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (res_valid && !res_stall) tracker.match_result(res_data);
		if (pix_valid && !pix_stall) tracker.take_pixel(pix_data);
	end

	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic send_pixel(logic [7:0] raw, logic pad_bit);
		if ($urandom_range(99) < send_gap_pct) begin
			pix_valid = 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		pix_valid = 1'b1;
		pix_data.raw_height = raw;
		pix_data.pad = pad_bit;
		do @(posedge clk); while (pix_stall);
		@(negedge clk);
		pixels_sent++;
	endtask

	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		tracker.write_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// The block may still be working on a beat that gives no result, so the
	// settle time covers the longest per-beat sequence.
	task automatic drain;
		pix_valid = 1'b0;
		while (tracker.pending_means.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic configure(int w, int h, int s, int o);
		drain();
		reg_write(hmsbf_pkg::REG_WIDTH, w);
		reg_write(hmsbf_pkg::REG_HEIGHT, h);
		reg_write(hmsbf_pkg::REG_SCALE, s);
		reg_write(hmsbf_pkg::REG_OFFSET, o & 32'hFFFFFF);
	endtask

	function automatic logic [7:0] pick_raw();
		case ($urandom_range(5))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_frame(int w, int h);
		for (int i = 0; i < w * (h + 1); i++) send_pixel(pick_raw(), 1'($urandom_range(1)));
	endtask

	initial begin
		int w, h, s, o, n;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Largest gain and offset over a 3x3 frame, all-extreme bytes.
		configure(3, 3, 65535, 8388607);
		for (int i = 0; i < 12; i++) send_pixel((i % 3 == 1) ? 8'd0 : 8'd255, i[0]);
		// Zero width and height act as one; most negative offset.
		configure(0, 0, 0, -8388608);
		for (int i = 0; i < 4; i++) send_pixel(8'd255, 1'b1);
		// Tallest height: a few rows, then a restart by a new write.
		configure(1, 65535, 1, -1);
		for (int i = 0; i < 5; i++) send_pixel(pick_raw(), 1'b0);

		while (pixels_sent < 370) begin
			if (pixels_sent > 250) begin
				send_gap_pct = 0;
				recv_stall_pct = 0;
			end else if (pixels_sent > 130) begin
				send_gap_pct = 47;
				recv_stall_pct = 29;
			end
			w = ($urandom_range(7) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
			h = $urandom_range(6, 1);
			case ($urandom_range(3))
				0: s = 0;
				1: s = 65535;
				default: s = $urandom_range(65535);
			endcase
			o = $urandom;
			configure(w, h, s, o);
			if ($urandom_range(7) == 0) begin
				n = $urandom_range(w * (h + 1) - 1);
				for (int i = 0; i < n; i++) send_pixel(pick_raw(), 1'($urandom_range(1)));
				continue;
			end
			repeat ($urandom_range(2, 1)) send_frame(w, h);
		end

		// Width above the maximum acts as the maximum; a short run in the first row.
		configure(2047, 1, $urandom_range(65535), $urandom);
		for (int i = 0; i < 24; i++) send_pixel(pick_raw(), 1'b0);

		drain();
		if (tracker.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
